FILE: rtl/key_matrix_sensor_calibrator_top_macros.svh
// Assertion helpers used by the calibrator controller (kmsc_ctrl).
`ifndef KEY_MATRIX_SENSOR_CALIBRATOR_TOP_MACROS_SVH
`define KEY_MATRIX_SENSOR_CALIBRATOR_TOP_MACROS_SVH

// same-cycle implication
`define KMSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kmsc assertion failed");

// next-cycle implication
`define KMSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kmsc assertion failed");

`endif

FILE: rtl/kmsc_pkg.sv
package kmsc_pkg;

    localparam int ROWS_DEF = 4;
    localparam int COLS_DEF = 16;
    localparam int ROW_W    = 2;
    localparam int COL_W    = 4;
    localparam int OP_W     = 3;
    localparam int DAT_W    = 8;
    localparam int CNT_OUT_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_W    = 16;

    localparam logic [OP_W-1:0] OP_START  = 3'd0;
    localparam logic [OP_W-1:0] OP_IDLE   = 3'd1;
    localparam logic [OP_W-1:0] OP_PRESS  = 3'd2;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd3;
    localparam logic [OP_W-1:0] OP_ACTIVE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK      = 2'd2;

    localparam logic [DAT_W-1:0] MIN_RST       = 8'hFF;
    localparam logic [DAT_W-1:0] ZERO_RST      = 8'h00;
    localparam logic [DAT_W-1:0] THRESHOLD_RST = 8'd5;
    localparam logic [DAT_W-1:0] PEAK_RST      = 8'd50;

    typedef struct packed {
        logic in_load;
        logic clr_tables;
        logic set_act;
        logic upd_wr;
        logic use_idx;
        logic div_start;
        logic fin_wr;
        logic out_load;
        logic acc_clr;
        logic idx_clr;
        logic idx_inc;
    } cmd_t;

    typedef struct packed {
        logic inside_in;
        logic last_key;
        logic div_busy;
    } sts_t;

endpackage

FILE: rtl/kmsc_div.sv
module kmsc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [kmsc_pkg::DIV_W-1:0]  dividend,
    input  logic [kmsc_pkg::DIV_W-1:0]  divisor,
    output logic                        busy,
    output logic [kmsc_pkg::DIV_W-1:0]  quotient
);
    import kmsc_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic [DIV_W:0]   rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;
    logic             ge;

    assign rem_sh = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_W-1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff : rem_sh;
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/kmsc_dp.sv
module kmsc_dp #(
    parameter int ROWS = kmsc_pkg::ROWS_DEF,
    parameter int COLS = kmsc_pkg::COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  kmsc_pkg::cmd_t                    cmd,
    output kmsc_pkg::sts_t                    sts,
    input  logic                              cfg_we,
    input  logic [kmsc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [kmsc_pkg::DAT_W-1:0]        cfg_wdata,
    input  logic [kmsc_pkg::OP_W-1:0]         s_op,
    input  logic [kmsc_pkg::ROW_W-1:0]        s_row,
    input  logic [kmsc_pkg::COL_W-1:0]        s_col,
    input  logic [kmsc_pkg::DAT_W-1:0]        s_sample,
    input  logic                              s_active_in,
    output logic [kmsc_pkg::ROW_W-1:0]        m_key_row,
    output logic [kmsc_pkg::COL_W-1:0]        m_key_col,
    output logic [kmsc_pkg::DAT_W-1:0]        m_snr,
    output logic [kmsc_pkg::DAT_W-1:0]        m_idle_min,
    output logic [kmsc_pkg::DAT_W-1:0]        m_idle_max,
    output logic [kmsc_pkg::DAT_W-1:0]        m_press_peak,
    output logic                              m_key_active,
    output logic [kmsc_pkg::DAT_W-1:0]        m_cal_min,
    output logic [kmsc_pkg::DAT_W-1:0]        m_cal_max,
    output logic [kmsc_pkg::DAT_W-1:0]        m_noise_floor,
    output logic [kmsc_pkg::CNT_OUT_W-1:0]    m_key_count,
    output logic                              m_last
);
    import kmsc_pkg::*;

    localparam int KEYS = ROWS * COLS;
    localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;

    logic             auto_reg;
    logic [DAT_W-1:0] thr_reg;
    logic [DAT_W-1:0] pfl_reg;

    logic [KW-1:0]    key_in;
    logic [KW-1:0]    key_reg;
    logic [OP_W-1:0]  op_reg;
    logic [DAT_W-1:0] sample_reg;
    logic [KW-1:0]    idx_reg;
    logic [ROW_W-1:0] r_reg;
    logic [COL_W-1:0] c_reg;
    logic [KW-1:0]    addr;

    logic [DAT_W-1:0] min_mem [KEYS];
    logic [DAT_W-1:0] max_mem [KEYS];
    logic [DAT_W-1:0] pk_mem  [KEYS];
    logic             act_mem [KEYS];
    logic [DAT_W-1:0] snr_mem [KEYS];
    logic [KEYS-1:0]  tab_vld_reg;
    logic [KEYS-1:0]  act_vld_reg;

    logic [DAT_W-1:0] rd_min_reg, rd_max_reg, rd_pk_reg, rd_snr_reg;
    logic             rd_act_reg, rd_tv_reg, rd_av_reg;
    logic [DAT_W-1:0] e_min, e_max, e_pk;
    logic             e_act;

    logic [DAT_W-1:0] new_min, new_max, new_pk;
    logic [DIV_W-1:0] noise, signal, dvs, quo;
    logic             div_busy;
    logic [DAT_W-1:0] snr_new, spread, half;
    logic             act_new;
    logic             act_we;
    logic [KW-1:0]    act_wa;
    logic             act_wd;

    logic [DAT_W-1:0]     floor_reg;
    logic [CNT_OUT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_reg <= 1'b0;
            thr_reg  <= THRESHOLD_RST;
            pfl_reg  <= PEAK_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_AUTO:      auto_reg <= cfg_wdata[0];
                CFG_THRESHOLD: thr_reg  <= cfg_wdata;
                CFG_PEAK:      pfl_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign key_in = KW'(int'(s_row) * COLS + int'(s_col));
    assign sts.inside_in = (int'(s_row) < ROWS) && (int'(s_col) < COLS);
    assign sts.last_key  = idx_reg == KW'(KEYS - 1);
    assign sts.div_busy  = div_busy;

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            key_reg    <= key_in;
            op_reg     <= s_op;
            sample_reg <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            r_reg   <= '0;
            c_reg   <= '0;
        end else if (cmd.idx_clr) begin
            idx_reg <= '0;
            r_reg   <= '0;
            c_reg   <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
            if (c_reg == COL_W'(COLS - 1)) begin
                c_reg <= '0;
                r_reg <= r_reg + 1'b1;
            end else begin
                c_reg <= c_reg + 1'b1;
            end
        end
    end

    assign addr = cmd.use_idx ? idx_reg : key_reg;

    always_ff @(posedge aclk) begin
        rd_min_reg <= min_mem[addr];
        rd_max_reg <= max_mem[addr];
        rd_pk_reg  <= pk_mem[addr];
        rd_act_reg <= act_mem[addr];
        rd_snr_reg <= snr_mem[addr];
        rd_tv_reg  <= tab_vld_reg[addr];
        rd_av_reg  <= act_vld_reg[addr];
    end

    assign e_min = rd_tv_reg ? rd_min_reg : MIN_RST;
    assign e_max = rd_tv_reg ? rd_max_reg : ZERO_RST;
    assign e_pk  = rd_tv_reg ? rd_pk_reg  : ZERO_RST;
    assign e_act = rd_av_reg & rd_act_reg;

    always_comb begin
        new_min = e_min;
        new_max = e_max;
        new_pk  = e_pk;
        if (op_reg == OP_IDLE) begin
            if (sample_reg < e_min) new_min = sample_reg;
            if (sample_reg > e_max) new_max = sample_reg;
        end else if (sample_reg > e_pk) begin
            new_pk = sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd_wr) begin
            min_mem[key_reg] <= new_min;
            max_mem[key_reg] <= new_max;
            pk_mem[key_reg]  <= new_pk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_vld_reg <= '0;
        end else if (cmd.clr_tables) begin
            tab_vld_reg <= '0;
        end else if (cmd.upd_wr) begin
            tab_vld_reg[key_reg] <= 1'b1;
        end
    end

    assign noise  = {8'h00, e_max} - {8'h00, e_min};
    assign signal = {8'h00, e_pk} - {8'h00, e_max};
    assign dvs    = (noise == '0) ? DIV_W'(1) : noise;

    kmsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (signal),
        .divisor  (dvs),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign snr_new = (e_pk < pfl_reg) ? ZERO_RST : quo[DAT_W-1:0];
    assign act_new = auto_reg ? (snr_new > thr_reg) : e_act;
    assign spread  = e_max - e_min;
    assign half    = floor_reg >> 1;

    always_ff @(posedge aclk) begin
        if (cmd.fin_wr) begin
            snr_mem[idx_reg] <= snr_new;
        end
    end

    assign act_we = (cmd.set_act && sts.inside_in) || (cmd.fin_wr && auto_reg);
    assign act_wa = cmd.set_act ? key_in : idx_reg;
    assign act_wd = cmd.set_act ? s_active_in : act_new;

    always_ff @(posedge aclk) begin
        if (act_we) begin
            act_mem[act_wa] <= act_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_vld_reg <= '0;
        end else if (act_we) begin
            act_vld_reg[act_wa] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= '0;
            count_reg <= '0;
        end else if (cmd.acc_clr) begin
            floor_reg <= '0;
            count_reg <= '0;
        end else if (cmd.fin_wr && act_new) begin
            if (spread > floor_reg) floor_reg <= spread;
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_key_row     <= r_reg;
            m_key_col     <= c_reg;
            m_snr         <= rd_snr_reg;
            m_idle_min    <= e_min;
            m_idle_max    <= e_max;
            m_press_peak  <= e_pk;
            m_key_active  <= e_act;
            m_cal_min     <= e_act ? e_min + half : ZERO_RST;
            m_cal_max     <= e_act ? e_pk - half : ZERO_RST;
            m_noise_floor <= floor_reg;
            m_key_count   <= count_reg;
            m_last        <= sts.last_key;
        end
    end

endmodule

FILE: rtl/kmsc_ctrl.sv
`include "key_matrix_sensor_calibrator_top_macros.svh"

module kmsc_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic [kmsc_pkg::OP_W-1:0]     s_op,
    output logic                          s_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output kmsc_pkg::cmd_t                cmd,
    input  kmsc_pkg::sts_t                sts
);
    import kmsc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_WR     = 4'd2;
    localparam logic [3:0] S_F_RD   = 4'd3;
    localparam logic [3:0] S_F_DIV0 = 4'd4;
    localparam logic [3:0] S_F_DIV  = 4'd5;
    localparam logic [3:0] S_F_WR   = 4'd6;
    localparam logic [3:0] S_O_RD   = 4'd7;
    localparam logic [3:0] S_O_LD   = 4'd8;
    localparam logic [3:0] S_O_WAIT = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_O_WAIT;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    case (s_op)
                        OP_START:  cmd.clr_tables = 1'b1;
                        OP_ACTIVE: cmd.set_act = 1'b1;
                        OP_IDLE, OP_PRESS: begin
                            if (sts.inside_in) state_next = S_RD;
                        end
                        OP_FINISH: begin
                            cmd.idx_clr = 1'b1;
                            cmd.acc_clr = 1'b1;
                            state_next  = S_F_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: state_next = S_WR;
            S_WR: begin
                cmd.upd_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_F_RD: begin
                cmd.use_idx = 1'b1;
                state_next  = S_F_DIV0;
            end
            S_F_DIV0: begin
                cmd.use_idx   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_F_DIV;
            end
            S_F_DIV: begin
                cmd.use_idx = 1'b1;
                if (!sts.div_busy) state_next = S_F_WR;
            end
            S_F_WR: begin
                cmd.use_idx = 1'b1;
                cmd.fin_wr  = 1'b1;
                if (sts.last_key) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_O_RD;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_F_RD;
                end
            end
            S_O_RD: begin
                cmd.use_idx = 1'b1;
                state_next  = S_O_LD;
            end
            S_O_LD: begin
                cmd.use_idx  = 1'b1;
                cmd.out_load = 1'b1;
                state_next   = S_O_WAIT;
            end
            S_O_WAIT: begin
                cmd.use_idx = 1'b1;
                if (m_ready) begin
                    if (sts.last_key) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_O_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `KMSC_ASSERT_IMP(a_no_overlap, aclk, aresetn, s_ready, !m_valid)
    `KMSC_ASSERT_IMP(a_div_done, aclk, aresetn, state_reg == S_F_WR, !sts.div_busy)
    `KMSC_ASSERT_NXT(a_finish_go, aclk, aresetn,
        s_valid && s_ready && s_op == OP_FINISH, state_reg == S_F_RD)

endmodule

FILE: rtl/key_matrix_sensor_calibrator_top.sv
// Key matrix sensor calibrator.
// Input channel s_*: one beat carries an op (start, idle sample, pressed sample,
// finish, set active) with key row/col, sample and active bit.
// Result channel m_*: only a finish produces beats, one per key in row-major
// order, m_last on the final key.
// Config port: cfg_we/cfg_idx/cfg_wdata writes auto_detect, detect threshold,
// peak_floor; write only while the block is idle.
// Start and set-active complete in the idle state; sample ops add a read state
// and an update state, since min/max/peak tables sit in registered-read memories.
// Finish runs ROWS*COLS keys through a restoring divider (read, divide, write
// back per key), then emits each key (read, load, wait for the receiver).
// No new input beat is taken until the last result beat is taken.
// A stalled receiver holds the current result beat and freezes the walk.
// Reset marks all tables and the active map as cleared through valid bits,
// so the block is ready in the first cycle after reset.
module key_matrix_sensor_calibrator_top #(
    parameter int ROWS = kmsc_pkg::ROWS_DEF,
    parameter int COLS = kmsc_pkg::COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [kmsc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [kmsc_pkg::DAT_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [kmsc_pkg::OP_W-1:0]         s_op,
    input  logic [kmsc_pkg::ROW_W-1:0]        s_row,
    input  logic [kmsc_pkg::COL_W-1:0]        s_col,
    input  logic [kmsc_pkg::DAT_W-1:0]        s_sample,
    input  logic                              s_active_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [kmsc_pkg::ROW_W-1:0]        m_key_row,
    output logic [kmsc_pkg::COL_W-1:0]        m_key_col,
    output logic [kmsc_pkg::DAT_W-1:0]        m_snr,
    output logic [kmsc_pkg::DAT_W-1:0]        m_idle_min,
    output logic [kmsc_pkg::DAT_W-1:0]        m_idle_max,
    output logic [kmsc_pkg::DAT_W-1:0]        m_press_peak,
    output logic                              m_key_active,
    output logic [kmsc_pkg::DAT_W-1:0]        m_cal_min,
    output logic [kmsc_pkg::DAT_W-1:0]        m_cal_max,
    output logic [kmsc_pkg::DAT_W-1:0]        m_noise_floor,
    output logic [kmsc_pkg::CNT_OUT_W-1:0]    m_key_count,
    output logic                              m_last
);
    import kmsc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    kmsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    kmsc_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .s_op          (s_op),
        .s_row         (s_row),
        .s_col         (s_col),
        .s_sample      (s_sample),
        .s_active_in   (s_active_in),
        .m_key_row     (m_key_row),
        .m_key_col     (m_key_col),
        .m_snr         (m_snr),
        .m_idle_min    (m_idle_min),
        .m_idle_max    (m_idle_max),
        .m_press_peak  (m_press_peak),
        .m_key_active  (m_key_active),
        .m_cal_min     (m_cal_min),
        .m_cal_max     (m_cal_max),
        .m_noise_floor (m_noise_floor),
        .m_key_count   (m_key_count),
        .m_last        (m_last)
    );

endmodule
